// ===== design/grp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the Gaussian RBF predictor.
// No dependencies; every other file of the block but grp_ram refers to this package.
package grp_pkg;

   localparam int OPCODE_W = 1;
   localparam int INDEX_W  = 6;
   localparam int COORD_W  = 16;
   localparam int WEIGHT_W = 32;
   localparam int PRED_W   = 48;
   localparam int GAMMA_W  = 24;
   localparam int COUNT_W  = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd65536;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd0;

   // One in Q2.30, used while the exponential table is built.
   localparam logic [63:0] FX_ONE = 64'd1 << 30;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAMMA   = 1'b0,
      CSR_CENTERS = 1'b1
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic start;
      logic issue;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } status_type;

   function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> 30;
   endfunction

   // Taylor series of exp(-f) for f in [0, 1], Q2.30 in and out. Evaluated
   // at elaboration only.
   function automatic logic [63:0] exp_neg_unit(input logic [63:0] f);
      logic [63:0] t;
      longint      s;
      t = FX_ONE;
      s = longint'(FX_ONE);
      t = fx_mul(t, f) / 64'd1;  s = s - longint'(t);
      t = fx_mul(t, f) / 64'd2;  s = s + longint'(t);
      t = fx_mul(t, f) / 64'd3;  s = s - longint'(t);
      t = fx_mul(t, f) / 64'd4;  s = s + longint'(t);
      t = fx_mul(t, f) / 64'd5;  s = s - longint'(t);
      t = fx_mul(t, f) / 64'd6;  s = s + longint'(t);
      t = fx_mul(t, f) / 64'd7;  s = s - longint'(t);
      t = fx_mul(t, f) / 64'd8;  s = s + longint'(t);
      t = fx_mul(t, f) / 64'd9;  s = s - longint'(t);
      t = fx_mul(t, f) / 64'd10; s = s + longint'(t);
      t = fx_mul(t, f) / 64'd11; s = s - longint'(t);
      t = fx_mul(t, f) / 64'd12; s = s + longint'(t);
      t = fx_mul(t, f) / 64'd13; s = s - longint'(t);
      t = fx_mul(t, f) / 64'd14; s = s + longint'(t);
      t = fx_mul(t, f) / 64'd15; s = s - longint'(t);
      t = fx_mul(t, f) / 64'd16; s = s + longint'(t);
      return (s < 0) ? 64'd0 : 64'(s);
   endfunction

endpackage

// ===== design/grp_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the Gaussian RBF predictor.
// Depends on grp_pkg for field widths and the opcode type.
interface grp_req_if;
   logic                               valid;
   logic                               ready;
   grp_pkg::opcode_type                opcode;
   logic [grp_pkg::INDEX_W-1:0]        center_index;
   logic signed [grp_pkg::COORD_W-1:0]  coord_a;
   logic signed [grp_pkg::COORD_W-1:0]  coord_b;
   logic signed [grp_pkg::WEIGHT_W-1:0] weight;

   modport source (output valid, opcode, center_index, coord_a, coord_b, weight,
                   input ready);
   modport sink (input valid, opcode, center_index, coord_a, coord_b, weight,
                 output ready);
endinterface

interface grp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [grp_pkg::PRED_W-1:0] prediction;
   logic                              saturated;

   modport source (output valid, prediction, saturated, input ready);
   modport sink (input valid, prediction, saturated, output ready);
endinterface

// ===== design/grp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module grp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/grp_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the Gaussian RBF predictor: center memory, kernel pipeline,
// accumulator and result register. Depends on grp_pkg, grp_if and grp_ram.
module grp_datapath #(
   parameter int MAX_CENTERS     = 64,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [grp_pkg::GAMMA_W-1:0]           gamma,
   input  logic [grp_pkg::INDEX_W-1:0]           req_center_index,
   input  logic signed [grp_pkg::COORD_W-1:0]    req_coord_a,
   input  logic signed [grp_pkg::COORD_W-1:0]    req_coord_b,
   input  logic signed [grp_pkg::WEIGHT_W-1:0]   req_weight,
   input  grp_pkg::cmd_type                      cmd,
   input  logic [((MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1)-1:0] rd_addr,
   output grp_pkg::status_type                   status,
   grp_rsp_if.source                             rsp
);
   localparam int AW      = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int CNT_W   = $clog2(MAX_CENTERS + 1);
   localparam int IXW     = (CNT_W > grp_pkg::INDEX_W) ? CNT_W : grp_pkg::INDEX_W;
   localparam int CW16    = grp_pkg::COORD_W;
   localparam int WW      = grp_pkg::WEIGHT_W;
   localparam int MEM_W   = 2 * CW16 + WW;
   localparam int SQ_W    = 32;
   localparam int D2_W    = SQ_W + 1;
   localparam int P_W     = grp_pkg::GAMMA_W + D2_W;
   localparam int P_LIM   = 44;                // kernel is zero from 16.0 in Q17.40 up
   localparam int FRAC_LO = P_LIM - 16;
   localparam int IW      = $clog2(EXP_TABLE_DEPTH);
   localparam int TW      = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int S_W     = P_LIM + IW;
   localparam int PROD_W  = 48;
   localparam int ACC_W   = PROD_W + $clog2(MAX_CENTERS);
   localparam int Q_W     = ACC_W - 16;
   localparam int PW      = grp_pkg::PRED_W;
   localparam int CMP_W   = (Q_W > PW) ? Q_W : PW;

   localparam logic signed [PW-1:0] PRED_MAX = {1'b0, {(PW - 1){1'b1}}};
   localparam logic signed [PW-1:0] PRED_MIN = {1'b1, {(PW - 1){1'b0}}};

   typedef logic [15:0] exp_tab_type [EXP_TABLE_DEPTH + 1];

   // exp(-16k/EXP_TABLE_DEPTH) in Q0.16, built at elaboration.
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] e1;
      logic [63:0] x;
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] q;
      e1 = grp_pkg::exp_neg_unit(grp_pkg::FX_ONE);
      for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
         x = (64'(k) << 34) / EXP_TABLE_DEPTH;
         n = x >> 30;
         r = grp_pkg::exp_neg_unit(x & (grp_pkg::FX_ONE - 64'd1));
         for (int i = 0; i < 64; i++) begin
            if (64'(i) < n) begin
               r = (r * e1) >> 30;
            end
         end
         q = (r + 64'd8192) >> 14;
         tab[k] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

   // Center memory: {coord_a, coord_b, weight} per entry.
   logic             wr_en;
   logic [MEM_W-1:0] rd_data;

   assign wr_en = cmd.load && (IXW'(req_center_index) < IXW'(MAX_CENTERS));

   grp_ram #(
      .WIDTH (MEM_W),
      .DEPTH (MAX_CENTERS)
   ) u_center_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_center_index)),
      .wr_data ({req_coord_a, req_coord_b, req_weight}),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Stage valids: memory read, squares, product, index, table, kernel, term.
   logic v_rd_ff, v_a_ff, v_b_ff, v_c_ff, v_d_ff, v_e_ff, v_f_ff;

   logic signed [CW16-1:0] pa_ff, pb_ff;

   logic signed [CW16:0]     da, db;
   logic signed [2*CW16+1:0] sq_a_full, sq_b_full;
   logic [SQ_W-1:0]          sq_a_ff, sq_b_ff;
   logic signed [WW-1:0]     w_a_ff, w_b_ff, w_c_ff, w_d_ff, w_e_ff;

   logic [D2_W-1:0] d2;
   logic [P_W-1:0]  p_in, p_ff;

   logic [S_W-1:0]  s_val;
   logic [IW-1:0]   idx_ff;
   logic [15:0]     frac_c_ff, frac_d_ff;
   logic            zero_c_ff, zero_d_ff;

   logic [15:0] tab_hi, tab_lo, tab_lo_c;
   logic [15:0] hi_ff, diff_ff;

   logic [31:0] mix;
   logic [15:0] kern_in, kern_ff;

   logic signed [PROD_W:0]   prod_full;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic signed [ACC_W-1:0] r_sum;
   logic signed [Q_W-1:0]   q_val;
   logic signed [CMP_W-1:0] q_ext;
   logic                    over_hi, over_lo;

   logic                 out_valid_ff;
   logic signed [PW-1:0] pred_ff;
   logic                 sat_ff;

   assign da        = {pa_ff[CW16-1], pa_ff} - {rd_data[MEM_W-1], rd_data[MEM_W-1 -: CW16]};
   assign db        = {pb_ff[CW16-1], pb_ff} - {rd_data[WW+CW16-1], rd_data[WW +: CW16]};
   assign sq_a_full = da * da;
   assign sq_b_full = db * db;

   assign d2   = {1'b0, sq_a_ff} + {1'b0, sq_b_ff};
   assign p_in = P_W'(gamma) * P_W'(d2);

   assign s_val = S_W'(p_ff[P_LIM-1:0]) * S_W'(EXP_TABLE_DEPTH);

   assign tab_hi   = EXP_TAB[TW'(idx_ff)];
   assign tab_lo   = EXP_TAB[TW'(idx_ff) + TW'(1)];
   assign tab_lo_c = (tab_lo > tab_hi) ? tab_hi : tab_lo;

   assign mix     = diff_ff * frac_d_ff;
   assign kern_in = zero_d_ff ? 16'd0 : (hi_ff - mix[31:16]);

   assign prod_full = w_e_ff * $signed({1'b0, kern_ff});

   // Round to nearest with ties toward plus infinity, then clip to 48 bits.
   assign r_sum   = acc_ff + ACC_W'(32768);
   assign q_val   = r_sum[ACC_W-1:16];
   assign q_ext   = CMP_W'(q_val);
   assign over_hi = q_ext > CMP_W'(PRED_MAX);
   assign over_lo = q_ext < CMP_W'(PRED_MIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_rd_ff      <= 1'b0;
         v_a_ff       <= 1'b0;
         v_b_ff       <= 1'b0;
         v_c_ff       <= 1'b0;
         v_d_ff       <= 1'b0;
         v_e_ff       <= 1'b0;
         v_f_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v_rd_ff <= cmd.issue;
         v_a_ff  <= v_rd_ff;
         v_b_ff  <= v_a_ff;
         v_c_ff  <= v_b_ff;
         v_d_ff  <= v_c_ff;
         v_e_ff  <= v_d_ff;
         v_f_ff  <= v_e_ff;
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pa_ff <= req_coord_a;
         pb_ff <= req_coord_b;
      end
      sq_a_ff   <= sq_a_full[SQ_W-1:0];
      sq_b_ff   <= sq_b_full[SQ_W-1:0];
      w_a_ff    <= rd_data[WW-1:0];
      p_ff      <= p_in;
      w_b_ff    <= w_a_ff;
      zero_c_ff <= |p_ff[P_W-1:P_LIM];
      idx_ff    <= s_val[S_W-1:P_LIM];
      frac_c_ff <= s_val[P_LIM-1:FRAC_LO];
      w_c_ff    <= w_b_ff;
      hi_ff     <= tab_hi;
      diff_ff   <= tab_hi - tab_lo_c;
      frac_d_ff <= frac_c_ff;
      zero_d_ff <= zero_c_ff;
      w_d_ff    <= w_c_ff;
      kern_ff   <= kern_in;
      w_e_ff    <= w_d_ff;
      prod_ff   <= prod_full[PROD_W-1:0];
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (v_f_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.finish) begin
         pred_ff <= over_hi ? PRED_MAX : (over_lo ? PRED_MIN : q_ext[PW-1:0]);
         sat_ff  <= over_hi || over_lo;
      end
   end

   assign status.pipe_busy = v_rd_ff || v_a_ff || v_b_ff || v_c_ff
                             || v_d_ff || v_e_ff || v_f_ff;
   assign status.out_free  = !out_valid_ff || rsp.ready;

   assign rsp.valid      = out_valid_ff;
   assign rsp.prediction = pred_ff;
   assign rsp.saturated  = sat_ff;
endmodule

// ===== design/grp_controller.sv =====
`timescale 1ns / 1ps
// Controller of the Gaussian RBF predictor: accepts items, walks the center
// memory for a query and hands off to the result register. Depends on grp_pkg.
module grp_controller #(
   parameter int MAX_CENTERS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  grp_pkg::opcode_type                   req_opcode,
   output logic                                  req_ready,
   input  logic [grp_pkg::COUNT_W-1:0]           centers_in_use,
   input  grp_pkg::status_type                   status,
   output grp_pkg::cmd_type                      cmd,
   output logic [((MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1)-1:0] rd_addr
);
   localparam int AW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int CNT_W = $clog2(MAX_CENTERS + 1);
   localparam int NW    = (CNT_W > grp_pkg::COUNT_W) ? CNT_W : grp_pkg::COUNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NW-1:0]    count_req;
   logic [CNT_W-1:0] count_lim;
   logic             accept;

   // A count above the memory depth walks the whole memory.
   assign count_req = (NW'(centers_in_use) > NW'(MAX_CENTERS)) ? NW'(MAX_CENTERS)
                                                               : NW'(centers_in_use);
   assign count_lim = CNT_W'(count_req);

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign cmd.load   = accept && (req_opcode == grp_pkg::OP_LOAD);
   assign cmd.start  = accept && (req_opcode == grp_pkg::OP_QUERY);
   assign cmd.issue  = (state_ff == ST_RUN);
   assign cmd.finish = (state_ff == ST_FINISH) && status.out_free;
   assign rd_addr    = addr_ff[AW-1:0];

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               addr_in  = '0;
               count_in = count_lim;
               state_in = (count_lim == '0) ? ST_DRAIN : ST_RUN;
            end
         end
         ST_RUN: begin
            addr_in = addr_ff + CNT_W'(1);
            if ((addr_ff + CNT_W'(1)) == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         count_ff <= count_in;
      end
   end

   // The kernel pipeline must be empty whenever a new item can be taken.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !status.pipe_busy)
      else $error("kernel pipeline busy while idle");

   // Every memory read stays inside the count captured for the query.
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (addr_ff < count_ff))
      else $error("memory read beyond the active center count");

   // The pipeline only empties out while the controller waits for it.
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      $fell(status.pipe_busy) |-> (state_ff == ST_DRAIN))
      else $error("pipeline emptied outside the drain phase");
endmodule

// ===== design/gaussian_rbf_predict.sv =====
`timescale 1ns / 1ps
// Gaussian RBF predictor, top level: configuration registers, controller
// and datapath. Depends on grp_pkg, grp_if, grp_controller and grp_datapath.
//
// Usage: req_ch carries items. A load item (opcode load) writes one center
// and its weight into the center memory in the cycle it is accepted and
// produces no response. A query item (opcode query) sums weight times
// exp(-gamma * squared distance) over the first centers_in_use entries and
// returns one item on rsp_ch: a Q32.16 prediction and a saturation flag.
// The csr port writes gamma (index 0) and centers_in_use (index 1); the user
// must write it only while no query is in flight. The block does not enforce it.
// Timing: one memory read per cycle feeds a seven-stage kernel pipeline,
// which then drains before the sum is rounded into the result register. A
// new item is taken right after that, even if the previous result still sits
// unclaimed in the result register; a query that finishes while the receiver
// stalls waits until the register frees.
// Reset returns gamma to 1.0 and centers_in_use to zero and clears the
// control state; the center memory keeps no reset value and entries must be
// loaded before a query reads them.
module gaussian_rbf_predict #(
   parameter int MAX_CENTERS     = 64,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   grp_req_if.sink                           req_ch,
   grp_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [grp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [grp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

   logic [grp_pkg::GAMMA_W-1:0] gamma_ff;
   logic [grp_pkg::COUNT_W-1:0] centers_ff;

   grp_pkg::cmd_type    cmd;
   grp_pkg::status_type status;
   logic [AW-1:0]       rd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff   <= grp_pkg::GAMMA_RESET;
         centers_ff <= grp_pkg::COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            grp_pkg::CSR_GAMMA: begin
               gamma_ff <= csr_wdata[grp_pkg::GAMMA_W-1:0];
            end
            grp_pkg::CSR_CENTERS: begin
               centers_ff <= csr_wdata[grp_pkg::COUNT_W-1:0];
            end
            default: begin
               gamma_ff <= gamma_ff;
            end
         endcase
      end
   end

   grp_controller #(
      .MAX_CENTERS (MAX_CENTERS)
   ) u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_opcode     (req_ch.opcode),
      .req_ready      (req_ch.ready),
      .centers_in_use (centers_ff),
      .status         (status),
      .cmd            (cmd),
      .rd_addr        (rd_addr)
   );

   grp_datapath #(
      .MAX_CENTERS     (MAX_CENTERS),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .gamma            (gamma_ff),
      .req_center_index (req_ch.center_index),
      .req_coord_a      (req_ch.coord_a),
      .req_coord_b      (req_ch.coord_b),
      .req_weight       (req_ch.weight),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .status           (status),
      .rsp              (rsp_ch)
   );
endmodule
